// File: design/mnso_pkg.sv
package mnso_pkg;

    // default configuration
    localparam int DEF_SAMPLE_RATE   = 48000;
    localparam int DEF_PHASE_BITS    = 32;
    localparam int DEF_SINE_LUT_BITS = 10;

    // field and datapath widths
    localparam int NOTE_W     = 7;
    localparam int NUM_NOTES  = 128;
    localparam int COUNT_W    = 64;
    localparam int SINE_MAG_W = 15;
    localparam int AMP_W      = 15;
    localparam int AMP_SHIFT  = 15;
    localparam int SAMPLE_W   = 16;

    // amplitude is round(32767 * vel / 127) = 258 * vel + (vel >= 64)
    localparam int AMP_STEP = 258;

    typedef enum logic [1:0] {
        CMD_SAMPLE   = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2
    } cmd_t;

    // 2^(r/12) in unsigned Q32: largest x whose truncated Q32 twelfth power stays <= 2^r
    function automatic logic [63:0] semitone_ratio(input int r);
        logic [63:0]  target;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  p;
        logic [127:0] wide;
        int           i;
        int           k;
        target = 64'd1 << (32 + r);
        lo     = 64'd1 << 32;
        hi     = 64'd1 << 33;
        for (i = 0; i < 32; i++) begin
            mid = lo + ((hi - lo) >> 1);
            p   = mid;
            for (k = 0; k < 11; k++) begin
                wide = {64'd0, p} * {64'd0, mid};
                p    = wide[95:32];
            end
            if (p <= target) begin
                lo = mid;
            end
            else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // quarter-wave sine entry j of 2^qbits, Q1.15, Taylor series in Q30
    function automatic logic [SINE_MAG_W-1:0] sine_quarter(input int j, input int qbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        t;
        logic [63:0]        v;
        logic signed [63:0] sum;
        int                 k;
        x    = (64'd1686629713 * 64'(j)) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (k = 1; k <= 8; k++) begin
            t = (term * x2) >> 30;
            unique case (k)
                1:       term = t / 64'd6;
                2:       term = t / 64'd20;
                3:       term = t / 64'd42;
                4:       term = t / 64'd72;
                5:       term = t / 64'd110;
                6:       term = t / 64'd156;
                7:       term = t / 64'd210;
                default: term = t / 64'd272;
            endcase
            if ((k % 2) == 1) begin
                sum = sum - $signed(term);
            end
            else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        v = (64'd32767 * 64'(sum) + 64'd536870912) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_MAG_W-1:0];
    endfunction

endpackage

// File: design/midi_note_sine_oscillator.sv
// sample command: the phase multiply, the sine ROM read, the amplitude product and the output
// register follow in that order; the next command is taken once the output register is loaded
// note on, note off and unused commands: no result and no stall
// the phase multiply takes one 16-bit chunk of the counter per cycle
// async active-low reset clears counter, note, velocity and the output valid
module midi_note_sine_oscillator
    import mnso_pkg::*;
#(
    parameter int SAMPLE_RATE   = DEF_SAMPLE_RATE,
    parameter int PHASE_BITS    = DEF_PHASE_BITS,
    parameter int SINE_LUT_BITS = DEF_SINE_LUT_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic [1:0]                 cmd,
    input  logic [NOTE_W-1:0]          note_number,
    input  logic [NOTE_W-1:0]          note_velocity,
    output logic                       sample_valid,
    input  logic                       sample_stall,
    output logic signed [SAMPLE_W-1:0] sample
);

    localparam int PROD_W = SINE_MAG_W + AMP_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_ROM  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [NOTE_W-1:0]     note_reg;
    logic [NOTE_W-1:0]     vel_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  neg_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SAMPLE_W-1:0]   sample_next;
    logic                  sample_valid_reg;
    logic                  cmd_accept;
    logic                  start;
    logic                  out_free;
    logic                  out_load;
    logic [PHASE_BITS-1:0] inc;
    logic [PHASE_BITS-1:0] phase;
    logic                  mac_done;
    logic                  rom_rd;
    logic [SINE_MAG_W-1:0] sine_mag;
    logic                  sine_neg;
    logic [AMP_W-1:0]      amp;
    logic [SAMPLE_W-1:0]   scaled_ext;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign start      = cmd_accept && (cmd == CMD_SAMPLE);
    assign out_free   = !sample_valid_reg || !sample_stall;
    assign out_load   = (state_reg == ST_OUT) && out_free;
    assign rom_rd     = (state_reg == ST_MAC) && mac_done;

    mnso_inc_rom #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS)
    ) u_inc_rom (
        .clk  (clk),
        .note (note_reg),
        .inc  (inc)
    );

    mnso_phase_mac #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .count (count_reg[PHASE_BITS-1:0]),
        .inc   (inc),
        .phase (phase),
        .done  (mac_done)
    );

    mnso_sine_rom #(
        .SINE_LUT_BITS (SINE_LUT_BITS)
    ) u_sine_rom (
        .clk   (clk),
        .rd_en (rom_rd),
        .idx   (phase[PHASE_BITS-1 -: SINE_LUT_BITS]),
        .mag   (sine_mag),
        .neg   (sine_neg)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_MAC;
            ST_MAC:  if (mac_done) state_next = ST_ROM;
            ST_ROM:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // command state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            note_reg         <= '0;
            vel_reg          <= '0;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_accept)
            begin
                unique case (cmd)
                    CMD_SAMPLE:   count_reg <= count_reg + COUNT_W'(1);
                    CMD_NOTE_ON:
                    begin
                        note_reg <= note_number;
                        vel_reg  <= note_velocity;
                    end
                    CMD_NOTE_OFF: vel_reg <= '0;
                    default:      ;
                endcase
            end
            if (out_load)
            begin
                sample_valid_reg <= 1'b1;
            end
            else if (sample_valid_reg && !sample_stall)
            begin
                sample_valid_reg <= 1'b0;
            end
        end
    end

    // velocity to amplitude without a divider
    assign amp = AMP_W'({8'd0, vel_reg} * 15'(AMP_STEP)) + AMP_W'(vel_reg[NOTE_W-1]);

    // magnitude scaling, truncated toward zero, sign restored
    assign scaled_ext  = SAMPLE_W'(prod_reg[PROD_W-1:AMP_SHIFT]);
    assign sample_next = neg_reg ? (~scaled_ext + SAMPLE_W'(1)) : scaled_ext;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROM)
        begin
            prod_reg <= PROD_W'(sine_mag) * PROD_W'(amp);
            neg_reg  <= sine_neg;
        end
        if (out_load)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample_valid = sample_valid_reg;
    assign sample       = $signed(sample_reg);

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && $past(start)) |-> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("sample counter did not advance by one");

    a_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_MAC))
        else $error("phase done outside the multiply state");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("sample valid rose outside the output state");

    a_note_off: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (cmd == CMD_NOTE_OFF)) |=> (vel_reg == '0))
        else $error("velocity not cleared by note off");

endmodule

// File: design/mnso_inc_rom.sv
module mnso_inc_rom
    import mnso_pkg::*;
#(
    parameter int SAMPLE_RATE = DEF_SAMPLE_RATE,
    parameter int PHASE_BITS  = DEF_PHASE_BITS
)
(
    input  logic                  clk,
    input  logic [NOTE_W-1:0]     note,
    output logic [PHASE_BITS-1:0] inc
);

    localparam logic [63:0] RATE64 = 64'(SAMPLE_RATE);

    // per-note phase increment, halves rounded up
    function automatic logic [63:0] inc_value(input int n);
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] rem;
        int          e;
        int          o;
        int          r;
        int          s;
        int          sh;
        int          i;
        e = n + 3;
        o = e / 12;
        r = e % 12;
        s = o - 6 + PHASE_BITS - 32;
        a = 64'd440 * semitone_ratio(r);
        if (s >= 0) begin
            q   = a / RATE64;
            rem = a % RATE64;
            for (i = 0; i < 32; i++) begin
                if (i < s) begin
                    q   = q << 1;
                    rem = rem << 1;
                    if (rem >= RATE64) begin
                        q   = q + 64'd1;
                        rem = rem - RATE64;
                    end
                end
            end
            if ({rem[62:0], 1'b0} >= RATE64) begin
                q = q + 64'd1;
            end
        end
        else begin
            sh = -s;
            q  = ((a / RATE64) + (64'd1 << (sh - 1))) >> sh;
        end
        return q;
    endfunction

    logic [PHASE_BITS-1:0] inc_tab [NUM_NOTES];
    logic [PHASE_BITS-1:0] inc_reg;

    // constant increment contents
    for (genvar g = 0; g < NUM_NOTES; g++) begin : g_inc
        localparam logic [63:0] INC_FULL = inc_value(g);
        assign inc_tab[g] = INC_FULL[PHASE_BITS-1:0];
    end

    // synchronous read of the current note
    always_ff @(posedge clk)
    begin
        inc_reg <= inc_tab[note];
    end

    assign inc = inc_reg;

endmodule

// File: design/mnso_sine_rom.sv
module mnso_sine_rom
    import mnso_pkg::*;
#(
    parameter int SINE_LUT_BITS = DEF_SINE_LUT_BITS
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [SINE_LUT_BITS-1:0] idx,
    output logic [SINE_MAG_W-1:0]    mag,
    output logic                     neg
);

    localparam int QBITS = SINE_LUT_BITS - 2;
    localparam int QSIZE = 1 << QBITS;
    localparam int AW    = QBITS + 1;

    logic [SINE_MAG_W-1:0] quarter_tab [QSIZE+1];
    logic [1:0]            quad;
    logic [QBITS-1:0]      j;
    logic [AW-1:0]         addr;
    logic [SINE_MAG_W-1:0] mag_reg;
    logic                  neg_reg;

    // quarter wave contents, entries 0 through QSIZE
    for (genvar g = 0; g <= QSIZE; g++) begin : g_quarter
        localparam logic [SINE_MAG_W-1:0] QV = sine_quarter(g, QBITS);
        assign quarter_tab[g] = QV;
    end

    // mirror odd quadrants, sign from the upper half
    assign quad = idx[SINE_LUT_BITS-1 -: 2];
    assign j    = idx[QBITS-1:0];
    assign addr = quad[0] ? (AW'(QSIZE) - {1'b0, j}) : {1'b0, j};

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mag_reg <= quarter_tab[addr];
            neg_reg <= quad[1];
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

// File: design/mnso_phase_mac.sv
module mnso_phase_mac
    import mnso_pkg::*;
#(
    parameter int PHASE_BITS = DEF_PHASE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PHASE_BITS-1:0] count,
    input  logic [PHASE_BITS-1:0] inc,
    output logic [PHASE_BITS-1:0] phase,
    output logic                  done
);

    localparam int CHUNK_W = 16;
    localparam int NCH     = (PHASE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W   = NCH * CHUNK_W;
    localparam int STEP_W  = (NCH > 1) ? $clog2(NCH) : 1;

    logic                  run_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  prod_vld_reg;
    logic                  last_reg;
    logic                  done_reg;
    logic [PAD_W-1:0]      cnt_sh_reg;
    logic [PHASE_BITS-1:0] inc_sh_reg;
    logic [PHASE_BITS-1:0] prod_reg;
    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] mul_a;
    logic [PHASE_BITS-1:0] mul_p;
    logic                  step_last;

    // one 16-bit chunk of the count per cycle against the shifted increment
    assign mul_a     = (step_reg == '0) ? inc : inc_sh_reg;
    assign mul_p     = mul_a * PHASE_BITS'(cnt_sh_reg[CHUNK_W-1:0]);
    assign step_last = (step_reg == STEP_W'(NCH - 1));

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            step_reg     <= '0;
            prod_vld_reg <= 1'b0;
            last_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_last)
                begin
                    run_reg <= 1'b0;
                end
            end
            prod_vld_reg <= run_reg;
            last_reg     <= run_reg && step_last;
            done_reg     <= prod_vld_reg && last_reg;
        end
    end

    // product and accumulate, modulo 2^PHASE_BITS
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_sh_reg <= PAD_W'(count);
            acc_reg    <= '0;
        end
        else
        begin
            if (run_reg)
            begin
                prod_reg   <= mul_p;
                inc_sh_reg <= mul_a << CHUNK_W;
                cnt_sh_reg <= cnt_sh_reg >> CHUNK_W;
            end
            if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    assign phase = acc_reg;
    assign done  = done_reg;

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && step_last) |-> ##2 done_reg)
        else $error("phase done did not follow the last chunk");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("phase done held longer than one cycle");

endmodule

// File: tb/tb_midi_note_sine_oscillator.sv
`timescale 1ns / 100ps

module tb_midi_note_sine_oscillator
    import mnso_pkg::*;
();

    localparam int RATE      = DEF_SAMPLE_RATE;
    localparam int PH_BITS   = DEF_PHASE_BITS;
    localparam int LUT_BITS  = DEF_SINE_LUT_BITS;
    localparam int QTR       = 1 << (LUT_BITS - 2);
    localparam int FULL      = 32767;
    localparam int N_DIR     = 25;
    localparam int N_RANDOM  = 1425;
    localparam int LONG_HOLD = 120;
    localparam int SETTLE    = 20;
    localparam int LIMIT     = 400000;
    localparam int MAX_PRINT = 40;

    // the one code the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]        op;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
        bit                check;
        int                want;
    } stim_row_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       cmd_valid     = 1'b0;
    logic                       cmd_stall;
    logic [1:0]                 cmd           = CMD_SAMPLE;
    logic [NOTE_W-1:0]          note_number   = '0;
    logic [NOTE_W-1:0]          note_velocity = '0;
    logic                       sample_valid;
    logic                       sample_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;

    // oscillator tables and predicted state
    logic [63:0]       ratio_q32 [12];
    logic [63:0]       note_step [NUM_NOTES];
    int                quarter_wave [QTR + 1];
    logic [63:0]       phase_mask;
    logic [63:0]       osc_count;
    logic [NOTE_W-1:0] osc_note;
    logic [NOTE_W-1:0] osc_vel;

    logic signed [SAMPLE_W-1:0] want_samples [$];
    stim_row_t                  directed [N_DIR];

    int errors          = 0;
    int cycle_count     = 0;
    int cmds_sent       = 0;
    int samples_checked = 0;
    int idle_pct        = 0;
    bit want_hold       = 1'b0;
    bit hold_done       = 1'b0;
    int hold_left       = 0;
    int burst_left      = 0;

    midi_note_sine_oscillator #(
        .SAMPLE_RATE   (RATE),
        .PHASE_BITS    (PH_BITS),
        .SINE_LUT_BITS (LUT_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .note_number   (note_number),
        .note_velocity (note_velocity),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample)
    );

    always #10 clk = ~clk;

    // twelfth power of a q32 value, each multiply truncated
    function automatic logic [63:0] q32_twelfth(input logic [63:0] x);
        logic [127:0] acc;
        acc = {64'd0, x};
        repeat (11) acc = (acc * x) >> 32;
        return acc[63:0];
    endfunction

    // sine lookup scaled by the velocity amplitude, truncated toward zero
    function automatic logic signed [SAMPLE_W-1:0] next_sample();
        logic [63:0] phase;
        int          idx;
        int          quad;
        int          j;
        int          s_val;
        int          amp;
        int          prod;
        int          mag;
        phase = (osc_count * note_step[osc_note]) & phase_mask;
        idx   = int'(phase >> (PH_BITS - LUT_BITS));
        quad  = (idx >> (LUT_BITS - 2)) & 3;
        j     = idx & (QTR - 1);
        if ((quad & 1) != 0)
            j = QTR - j;
        s_val = ((quad & 2) != 0) ? -quarter_wave[j] : quarter_wave[j];
        amp   = (FULL * int'(osc_vel) + 63) / 127;
        prod  = s_val * amp;
        mag   = (prod < 0 ? -prod : prod) >>> 15;
        return SAMPLE_W'(prod < 0 ? -mag : mag);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (errors < MAX_PRINT)
            $display("MISMATCH %s: got %0d expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        errors++;
    endtask

    // update the predicted state for one accepted command
    task automatic absorb_cmd(input logic [1:0] op, input logic [NOTE_W-1:0] nt,
                              input logic [NOTE_W-1:0] vl, input bit check,
                              input int want);
        logic signed [SAMPLE_W-1:0] s;
        case (op)
            CMD_SAMPLE:
            begin
                s = next_sample();
                want_samples.push_back(check ? SAMPLE_W'(want) : s);
                osc_count++;
            end
            CMD_NOTE_ON:
            begin
                osc_note = nt;
                osc_vel  = vl;
            end
            CMD_NOTE_OFF:
            begin
                osc_vel = '0;
            end
            default:
            begin
            end
        endcase
        cmds_sent++;
    endtask

    // offer one command from a falling edge, return at the falling edge after the transfer
    task automatic send_cmd(input logic [1:0] op, input logic [NOTE_W-1:0] nt,
                            input logic [NOTE_W-1:0] vl, input bit check, input int want);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        cmd_valid     <= 1'b1;
        cmd           <= op;
        note_number   <= nt;
        note_velocity <= vl;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        absorb_cmd(op, nt, vl, check, want);
        @(negedge clk);
    endtask

    // build ratio, increment and quarter-wave tables
    initial
    begin : build_roms
        logic [63:0]        lo;
        logic [63:0]        hi;
        logic [63:0]        mid;
        logic [127:0]       num;
        logic [127:0]       den;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        longint             acc;
        int                 e;
        int                 sh;
        phase_mask = {64{1'b1}} >> (64 - PH_BITS);
        for (int r = 0; r < 12; r++)
        begin
            lo = 64'd1 << 32;
            hi = 64'd1 << 33;
            while (hi - lo > 64'd1)
            begin
                mid = lo + ((hi - lo) >> 1);
                if (q32_twelfth(mid) <= (64'd1 << (32 + r)))
                    lo = mid;
                else
                    hi = mid;
            end
            ratio_q32[r] = lo;
        end
        for (int n = 0; n < NUM_NOTES; n++)
        begin
            e   = n + 3;
            sh  = e / 12 - 6 + PH_BITS - 32;
            num = 128'd440 * ratio_q32[e % 12];
            den = 128'(RATE);
            if (sh >= 0)
                num = num << sh;
            else
                den = den << (-sh);
            note_step[n] = 64'((2 * num + den) / (2 * den)) & phase_mask;
        end
        for (int j = 0; j <= QTR; j++)
        begin
            x    = (64'd1686629713 * 64'(j)) >> (LUT_BITS - 2);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 8; k++)
            begin
                term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
                if ((k % 2) == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            v = (64'd32767 * 64'(acc) + (64'd1 << 29)) >> 30;
            quarter_wave[j] = (v > 64'(FULL)) ? FULL : int'(v);
        end
        osc_count = '0;
        osc_note  = '0;
        osc_vel   = '0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout with %0d samples outstanding", want_samples.size());
            $display("Verification failed");
            $finish;
        end
    end

    // output stall: random bursts plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            sample_stall <= 1'b1;
            hold_left    <= hold_left - 1;
            if (hold_left == 1)
                hold_done <= 1'b1;
        end
        else if (want_hold && !hold_done)
        begin
            sample_stall <= 1'b1;
            hold_left    <= LONG_HOLD;
        end
        else if (burst_left != 0)
        begin
            sample_stall <= 1'b1;
            burst_left   <= burst_left - 1;
        end
        else if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
        begin
            sample_stall <= 1'b1;
            burst_left   <= $urandom_range(0, 10);
        end
        else
        begin
            sample_stall <= 1'b0;
        end
    end

    // check each sample transfer against the oldest prediction
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] due;
        if (rst_n && sample_valid && !sample_stall)
        begin
            if (want_samples.size() == 0)
            begin
                flag_mismatch("sample with none pending", int'(sample), 0);
            end
            else
            begin
                due = want_samples.pop_front();
                if (sample !== due)
                    flag_mismatch("sample", int'(sample), int'(due));
                samples_checked++;
            end
        end
    end

    initial
    begin
        logic [1:0]        op;
        logic [NOTE_W-1:0] nt;
        logic [NOTE_W-1:0] vl;
        int                pick;
        int                fed;
        bit                drained;

        // directed rows: reset state, extremes, note off, unused code
        directed = '{
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b1, 0},
            '{CMD_SAMPLE,   7'd127, 7'd127, 1'b1, 0},
            '{CMD_NOTE_ON,  7'd69,  7'd127, 1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b0, 0},
            '{CMD_SAMPLE,   7'd127, 7'd127, 1'b0, 0},
            '{CMD_UNUSED,   7'd127, 7'd127, 1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b0, 0},
            '{CMD_NOTE_OFF, 7'd85,  7'd42,  1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b1, 0},
            '{CMD_NOTE_ON,  7'd127, 7'd127, 1'b0, 0},
            '{CMD_SAMPLE,   7'd42,  7'd85,  1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b0, 0},
            '{CMD_NOTE_ON,  7'd0,   7'd1,   1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b0, 0},
            '{CMD_NOTE_ON,  7'd0,   7'd64,  1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b0, 0},
            '{CMD_NOTE_ON,  7'd127, 7'd63,  1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b0, 0},
            '{CMD_NOTE_ON,  7'd60,  7'd0,   1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b1, 0},
            '{CMD_NOTE_ON,  7'd100, 7'd100, 1'b0, 0},
            '{CMD_UNUSED,   7'd0,   7'd0,   1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b0, 0},
            '{CMD_NOTE_OFF, 7'd0,   7'd0,   1'b0, 0},
            '{CMD_SAMPLE,   7'd0,   7'd0,   1'b1, 0}
        };

        // reset held at the start, released on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_pct = 25;
        foreach (directed[i])
            send_cmd(directed[i].op, directed[i].note, directed[i].vel,
                     directed[i].check, directed[i].want);

        // random part: mostly samples, note changes in between, some noise
        fed     = 0;
        drained = 1'b0;
        while (fed < N_RANDOM)
        begin
            if (fed >= N_RANDOM - 150)
                idle_pct = 0;
            else if (fed >= 500 && fed < 650)
                idle_pct = 0;
            else
                idle_pct = 25;
            if (fed >= 300)
                want_hold = 1'b1;

            // sender pause until every pending sample has come out
            if (fed >= 800 && !drained)
            begin
                drained = 1'b1;
                cmd_valid <= 1'b0;
                @(negedge clk);
                while (want_samples.size() != 0)
                    @(negedge clk);
            end

            pick = $urandom_range(0, 99);
            nt   = NOTE_W'($urandom_range(0, NUM_NOTES - 1));
            vl   = NOTE_W'($urandom_range(0, NUM_NOTES - 1));
            if (pick < 68)
            begin
                op = CMD_SAMPLE;
            end
            else if (pick < 86)
            begin
                op = CMD_NOTE_ON;
                if ($urandom_range(0, 9) == 0)
                    vl = $urandom_range(0, 1) ? 7'd127 : 7'd0;
            end
            else if (pick < 94)
            begin
                op = CMD_NOTE_OFF;
            end
            else
            begin
                op = CMD_UNUSED;
            end
            send_cmd(op, nt, vl, 1'b0, 0);
            fed++;
        end

        // drain and let the last commands settle
        cmd_valid <= 1'b0;
        while (want_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("%0d commands transferred, %0d samples compared, %0d mismatches",
                 cmds_sent, samples_checked, errors);
        $display("notes and velocities swept over their range, output hold and drain included");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
